/* hdl/sarrip_pkg.sv */
// Package for the stream-aware RRIP replacement core: field widths, codes and shared types.
// No dependencies; imported by every module of the block.
package sarrip_pkg;

    localparam int SET_IDX_W = 11;
    localparam int WAY_IDX_W = 4;
    localparam int MASK_W    = 16;
    localparam int ADDR_W    = 64;
    localparam int DELTA_W   = 32;
    localparam int LIMIT_W   = 16;
    localparam int THR_W     = 2;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic KIND_VICTIM = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    localparam logic REG_STRIDE_LIMIT = 1'b0;
    localparam logic REG_STREAM_THR   = 1'b1;

    localparam logic [1:0] RRPV_NEAR  = 2'd0;
    localparam logic [1:0] RRPV_LONG  = 2'd2;
    localparam logic [1:0] RRPV_MAX   = 2'd3;
    localparam logic [1:0] REUSE_INIT = 2'd1;
    localparam logic [1:0] REUSE_HOT  = 2'd2;
    localparam logic [1:0] REUSE_MAX  = 2'd3;
    localparam logic [1:0] SCORE_MAX  = 2'd3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd512;
    localparam logic [THR_W-1:0]   THR_RESET   = 2'd2;
    localparam logic [DELTA_W-1:0] DELTA_NOABS = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]         score;
        logic [DELTA_W-1:0] delta;
        logic [ADDR_W-1:0]  addr;
    } t_det;

    typedef struct packed {
        logic                 kind;
        logic [WAY_IDX_W-1:0] way;
        logic [MASK_W-1:0]    mask;
        logic [ADDR_W-1:0]    addr;
        logic                 hit;
    } t_req;

    typedef struct packed {
        logic [LIMIT_W-1:0] limit;
        logic [THR_W-1:0]   thr;
    } t_cfg;

endpackage

/* hdl/sarrip_row_update.sv */
// Next-value logic for one set row: victim search, aging, stride detector and per-way update.
// Depends on sarrip_pkg.
module sarrip_row_update #(
    parameter int NUM_WAYS = 16
) (
    input  sarrip_pkg::t_req                       i_req,
    input  logic                                   i_set_ok,
    input  sarrip_pkg::t_cfg                       i_cfg,
    input  sarrip_pkg::t_det                       i_det,
    input  logic [NUM_WAYS-1:0][1:0]               i_rrpv,
    input  logic [NUM_WAYS-1:0][1:0]               i_reuse,
    output sarrip_pkg::t_det                       o_det,
    output logic [NUM_WAYS-1:0][1:0]               o_rrpv,
    output logic [NUM_WAYS-1:0][1:0]               o_reuse,
    output logic                                   o_we,
    output logic [sarrip_pkg::WAY_IDX_W-1:0]       o_victim
);
    import sarrip_pkg::*;

    localparam int MASK_N = (NUM_WAYS < MASK_W) ? NUM_WAYS : MASK_W;

    logic                     inv_found;
    logic [WAY_IDX_W-1:0]     inv_way;
    logic [WAY_IDX_W-1:0]     age_way;
    logic [1:0]               top;
    logic [1:0]               age;
    logic [NUM_WAYS-1:0][1:0] aged;
    logic [DELTA_W-1:0]       delta;
    logic [DELTA_W-1:0]       mag;
    logic                     short_stride;
    logic                     bump;
    logic [1:0]               score_n;
    logic                     streaming;
    logic                     way_ok;
    logic [1:0]               ins;

    always_comb begin
        inv_found = 1'b0;
        inv_way   = '0;
        for (int i = MASK_N - 1; i >= 0; i--) begin
            if (!i_req.mask[i]) begin
                inv_found = 1'b1;
                inv_way   = WAY_IDX_W'(i);
            end
        end

        top = RRPV_NEAR;
        for (int i = 0; i < NUM_WAYS; i++) begin
            if (i_rrpv[i] > top) begin
                top = i_rrpv[i];
            end
        end
        age = RRPV_MAX - top;

        age_way = '0;
        for (int i = NUM_WAYS - 1; i >= 0; i--) begin
            aged[i] = i_rrpv[i] + age;
            if (aged[i] == RRPV_MAX) begin
                age_way = WAY_IDX_W'(i);
            end
        end
    end

    assign o_victim = inv_found ? inv_way : (i_set_ok ? age_way : '0);

    always_comb begin
        delta        = i_req.addr[DELTA_W-1:0] - i_det.addr[DELTA_W-1:0];
        mag          = delta[DELTA_W-1] ? (~delta + 1'b1) : delta;
        short_stride = (i_det.addr != '0) && (delta != DELTA_NOABS)
                       && (mag < DELTA_W'(i_cfg.limit));
        bump         = short_stride && (delta == i_det.delta) && (delta != '0);
        if (bump) begin
            score_n = (i_det.score == SCORE_MAX) ? i_det.score : i_det.score + 2'd1;
        end else begin
            score_n = (i_det.score == 2'd0) ? i_det.score : i_det.score - 2'd1;
        end
        streaming = score_n >= i_cfg.thr;
        way_ok    = 32'(i_req.way) < NUM_WAYS;
    end

    always_comb begin
        o_det   = i_det;
        o_rrpv  = i_rrpv;
        o_reuse = i_reuse;
        o_we    = 1'b0;
        ins     = RRPV_LONG;
        if (i_req.kind == KIND_VICTIM) begin
            o_we   = i_set_ok && !inv_found;
            o_rrpv = aged;
        end else begin
            o_we    = i_set_ok;
            o_det   = '{score: score_n, delta: delta, addr: i_req.addr};
            for (int i = 0; i < NUM_WAYS; i++) begin
                if (way_ok && (32'(i_req.way) == i)) begin
                    if (i_req.hit) begin
                        o_rrpv[i] = RRPV_NEAR;
                        if (i_reuse[i] != REUSE_MAX) begin
                            o_reuse[i] = i_reuse[i] + 2'd1;
                        end
                    end else begin
                        if (i_reuse[i] >= REUSE_HOT) begin
                            ins = RRPV_NEAR;
                        end else if (streaming) begin
                            ins = RRPV_MAX;
                        end else begin
                            ins = RRPV_LONG;
                        end
                        o_rrpv[i]  = ins;
                        o_reuse[i] = REUSE_INIT;
                    end
                end
            end
        end
    end

endmodule

/* hdl/stream_aware_rrip_replacement_core.sv */
// Top level of the stream-aware RRIP replacement core: set memory, control and register port.
// Depends on sarrip_pkg and sarrip_row_update.
//
// Input channel (i_in_valid/o_in_ready) carries one beat per victim request or access update.
// Output channel (o_out_valid/i_out_ready) carries one victim way per victim request;
// updates produce no beat.
// Each set lives in one row of a single-port-style memory with a registered read.
// A beat accepted in idle reads its row into a register. When the modify state completes,
// the row is rewritten (for an in-range set, unless a victim request finds an invalid way)
// and a victim request's result is loaded into the output register, visible in the same
// cycle as the core is ready again. No new beat is taken before that read-modify-write ends.
// If the output register still holds an untaken result, a victim request waits in its
// modify cycle until the receiver takes it; updates never wait on the output side.
// After reset the core sweeps all NUM_SETS rows to their initial values, one row per
// cycle, with o_in_ready low. Register writes through the APB port are taken at any time,
// including during that sweep.
// Registers: stride_limit at byte address 0, stream_threshold at byte address 4.
module stream_aware_rrip_replacement_core #(
    parameter int NUM_SETS = 2048,
    parameter int NUM_WAYS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_kind,
    input  logic [sarrip_pkg::SET_IDX_W-1:0]     i_set_index,
    input  logic [sarrip_pkg::WAY_IDX_W-1:0]     i_way_index,
    input  logic [sarrip_pkg::MASK_W-1:0]        i_valid_mask,
    input  logic [sarrip_pkg::ADDR_W-1:0]        i_phys_addr,
    input  logic                                 i_was_hit,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [sarrip_pkg::WAY_IDX_W-1:0]     o_victim_way,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sarrip_pkg::PADDR_W-1:0]       paddr,
    input  logic [sarrip_pkg::PDATA_W-1:0]       pwdata,
    output logic [sarrip_pkg::PDATA_W-1:0]       prdata,
    output logic                                 pready
);
    import sarrip_pkg::*;

    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

    typedef struct packed {
        t_det                     det;
        logic [NUM_WAYS-1:0][1:0] reuse;
        logic [NUM_WAYS-1:0][1:0] rrpv;
    } t_row;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RMW
    } t_state;

    t_state               r_state;
    logic [SET_W-1:0]     r_clr_cnt;
    t_req                 r_req;
    logic [SET_W-1:0]     r_set;
    logic                 r_set_ok;
    logic                 r_out_valid;
    logic [WAY_IDX_W-1:0] r_victim;
    logic [LIMIT_W-1:0]   r_limit;
    logic [THR_W-1:0]     r_thr;

    t_row                 r_mem [NUM_SETS];
    t_row                 r_rd_row;

    t_row                 w_clr_row;
    t_row                 w_upd_row;
    t_row                 w_wr_row;
    logic [SET_W-1:0]     w_wr_addr;
    logic                 w_upd_we;
    logic                 w_mem_we;
    logic [WAY_IDX_W-1:0] w_victim;
    logic                 w_in_acc;
    logic                 w_need_out;
    logic                 w_go;
    logic                 w_push;
    logic                 w_cfg_we;
    t_cfg                 w_cfg;

    assign o_in_ready   = (r_state == S_IDLE);
    assign w_in_acc     = i_in_valid && o_in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_victim_way = r_victim;
    assign pready       = 1'b1;
    assign w_cfg_we     = psel && penable && pwrite && pready;
    assign w_cfg        = '{limit: r_limit, thr: r_thr};

    always_comb begin
        w_clr_row.det = '0;
        for (int i = 0; i < NUM_WAYS; i++) begin
            w_clr_row.reuse[i] = REUSE_INIT;
            w_clr_row.rrpv[i]  = RRPV_MAX;
        end
    end

    sarrip_row_update #(
        .NUM_WAYS (NUM_WAYS)
    ) u_row_update (
        .i_req    (r_req),
        .i_set_ok (r_set_ok),
        .i_cfg    (w_cfg),
        .i_det    (r_rd_row.det),
        .i_rrpv   (r_rd_row.rrpv),
        .i_reuse  (r_rd_row.reuse),
        .o_det    (w_upd_row.det),
        .o_rrpv   (w_upd_row.rrpv),
        .o_reuse  (w_upd_row.reuse),
        .o_we     (w_upd_we),
        .o_victim (w_victim)
    );

    assign w_need_out = (r_req.kind == KIND_VICTIM);
    assign w_go       = (r_state == S_RMW) && (!w_need_out || !r_out_valid || i_out_ready);
    assign w_push     = w_go && w_need_out;
    assign w_mem_we   = (r_state == S_CLEAR) || (w_go && w_upd_we);
    assign w_wr_addr  = (r_state == S_CLEAR) ? r_clr_cnt : r_set;
    assign w_wr_row   = (r_state == S_CLEAR) ? w_clr_row : w_upd_row;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_wr_addr] <= w_wr_row;
        end
        if (w_in_acc) begin
            r_rd_row <= r_mem[SET_W'(i_set_index)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    if (r_clr_cnt == SET_W'(NUM_SETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_RMW;
                    end
                end
                S_RMW: begin
                    if (w_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_in_acc) begin
            r_req    <= '{kind: i_kind, way: i_way_index, mask: i_valid_mask,
                          addr: i_phys_addr, hit: i_was_hit};
            r_set    <= SET_W'(i_set_index);
            r_set_ok <= 32'(i_set_index) < NUM_SETS;
        end
        if (w_push) begin
            r_victim <= w_victim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_thr   <= THR_RESET;
        end else if (w_cfg_we) begin
            case (paddr[2])
                REG_STRIDE_LIMIT: r_limit <= pwdata[LIMIT_W-1:0];
                REG_STREAM_THR:   r_thr   <= pwdata[THR_W-1:0];
                default:          r_thr   <= r_thr;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_STRIDE_LIMIT: prdata = PDATA_W'(r_limit);
            REG_STREAM_THR:   prdata = PDATA_W'(r_thr);
            default:          prdata = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_accept_to_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_RMW))
        else $error("accepted beat did not enter the modify cycle");

    a_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> ((r_state == S_CLEAR) || (r_state == S_RMW)))
        else $error("set memory written outside sweep or modify cycle");

    a_push_victim_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (r_req.kind == KIND_VICTIM))
        else $error("result produced for an access update");

    a_push_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && r_out_valid) |-> i_out_ready)
        else $error("pending result overwritten before it was taken");

    a_clear_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CLEAR) && (r_clr_cnt == SET_W'(NUM_SETS - 1))) |=> (r_state == S_IDLE))
        else $error("clearing sweep did not end at the last set");
`endif

endmodule

/* verif/tb_stream_aware_rrip_replacement_core.sv */
// Testbench for stream_aware_rrip_replacement_core: directed and random victim requests and
// access updates, checked against an in-bench model of the RRIP sets and the stride detector.
// Depends on sarrip_pkg and the core RTL; the APB registers are written between phases.
module tb_stream_aware_rrip_replacement_core;
    import sarrip_pkg::*;

    localparam int NUM_SETS    = 2048;
    localparam int NUM_WAYS    = 16;
    localparam int POOL_SIZE   = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 4;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic                 kind;
        logic [SET_IDX_W-1:0] set_idx;
        logic [WAY_IDX_W-1:0] way;
        logic [MASK_W-1:0]    mask;
        logic [ADDR_W-1:0]    addr;
        logic                 hit;
    } t_op;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_kind = 1'b0;
    logic [SET_IDX_W-1:0] i_set_index = '0;
    logic [WAY_IDX_W-1:0] i_way_index = '0;
    logic [MASK_W-1:0]    i_valid_mask = '0;
    logic [ADDR_W-1:0]    i_phys_addr = '0;
    logic                 i_was_hit = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [WAY_IDX_W-1:0] o_victim_way;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Model of the block's state and registers.
    logic [1:0]           rrpv_tab [NUM_SETS][NUM_WAYS];
    logic [1:0]           reuse_tab [NUM_SETS][NUM_WAYS];
    logic [ADDR_W-1:0]    hist_addr [NUM_SETS];
    logic [DELTA_W-1:0]   hist_delta [NUM_SETS];
    logic [1:0]           stream_lvl [NUM_SETS];
    logic [LIMIT_W-1:0]   cur_limit;
    logic [THR_W-1:0]     cur_thr;

    logic [WAY_IDX_W-1:0] victims_due [$];
    logic [WAY_IDX_W-1:0] way_due;
    int                   fail_count = 0;
    int                   cycle_count = 0;

    bit                   hold_request = 1'b0;
    int                   hold_left = 0;
    int                   rx_left = 0;
    int                   rx_mode = 0;

    logic [SET_IDX_W-1:0] pool_set [POOL_SIZE];
    logic [ADDR_W-1:0]    pool_addr [POOL_SIZE];
    int                   pool_step [POOL_SIZE];

    stream_aware_rrip_replacement_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_set_index  (i_set_index),
        .i_way_index  (i_way_index),
        .i_valid_mask (i_valid_mask),
        .i_phys_addr  (i_phys_addr),
        .i_was_hit    (i_was_hit),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_victim_way (o_victim_way),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("stream_aware_rrip_replacement_core verification failed");
            $finish;
        end
    end

    function automatic logic [WAY_IDX_W-1:0] choose_victim(input logic [SET_IDX_W-1:0] s,
                                                           input logic [MASK_W-1:0] m);
        logic [1:0] top;
        logic [1:0] lift;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (!m[w]) return WAY_IDX_W'(w);
        end
        top = 2'd0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (rrpv_tab[s][w] > top) top = rrpv_tab[s][w];
        end
        lift = RRPV_MAX - top;
        for (int w = 0; w < NUM_WAYS; w++) rrpv_tab[s][w] = rrpv_tab[s][w] + lift;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (rrpv_tab[s][w] == RRPV_MAX) return WAY_IDX_W'(w);
        end
        return '0;
    endfunction

    function automatic void apply_access(input logic [SET_IDX_W-1:0] s,
                                         input logic [WAY_IDX_W-1:0] w,
                                         input logic [ADDR_W-1:0] a, input logic hit);
        logic [DELTA_W-1:0] d;
        logic [DELTA_W-1:0] mag;
        logic               short_step;
        logic [1:0]         ins;
        d = a[DELTA_W-1:0] - hist_addr[s][DELTA_W-1:0];
        mag = d[DELTA_W-1] ? (~d + 32'd1) : d;
        short_step = (hist_addr[s] != '0) && (d != DELTA_NOABS) &&
                     (mag < {16'd0, cur_limit});
        if (short_step && d == hist_delta[s] && d != '0) begin
            if (stream_lvl[s] < SCORE_MAX) stream_lvl[s] = stream_lvl[s] + 2'd1;
        end else if (stream_lvl[s] > 2'd0) begin
            stream_lvl[s] = stream_lvl[s] - 2'd1;
        end
        hist_delta[s] = d;
        hist_addr[s] = a;
        if (hit) begin
            rrpv_tab[s][w] = RRPV_NEAR;
            if (reuse_tab[s][w] < REUSE_MAX) reuse_tab[s][w] = reuse_tab[s][w] + 2'd1;
        end else begin
            ins = RRPV_LONG;
            if (stream_lvl[s] >= cur_thr) ins = RRPV_MAX;
            if (reuse_tab[s][w] >= REUSE_HOT) ins = RRPV_NEAR;
            rrpv_tab[s][w] = ins;
            reuse_tab[s][w] = REUSE_INIT;
        end
    endfunction

    function automatic t_op make_victim(input logic [SET_IDX_W-1:0] s,
                                        input logic [MASK_W-1:0] m);
        t_op op;
        op.kind = KIND_VICTIM;
        op.set_idx = s;
        op.mask = m;
        op.way = WAY_IDX_W'($urandom_range(0, NUM_WAYS - 1));
        op.addr = {$urandom, $urandom};
        op.hit = 1'($urandom_range(0, 1));
        return op;
    endfunction

    function automatic t_op make_access(input logic [SET_IDX_W-1:0] s,
                                        input logic [WAY_IDX_W-1:0] w,
                                        input logic [ADDR_W-1:0] a, input logic hit);
        t_op op;
        op.kind = KIND_UPDATE;
        op.set_idx = s;
        op.way = w;
        op.addr = a;
        op.hit = hit;
        op.mask = MASK_W'($urandom);
        return op;
    endfunction

    task automatic send_op(input t_op op);
        @(negedge i_clk);
        i_kind <= op.kind;
        i_set_index <= op.set_idx;
        i_way_index <= op.way;
        i_valid_mask <= op.mask;
        i_phys_addr <= op.addr;
        i_was_hit <= op.hit;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (op.kind == KIND_VICTIM) victims_due.push_back(choose_victim(op.set_idx, op.mask));
        else apply_access(op.set_idx, op.way, op.addr, op.hit);
    endtask

    task automatic idle_input(input int cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic settle();
        idle_input(1);
        while (victims_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] want;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_STRIDE_LIMIT) cur_limit = value[LIMIT_W-1:0];
        else cur_thr = value[THR_W-1:0];
        @(negedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        want = (idx == REG_STRIDE_LIMIT) ? PDATA_W'(cur_limit) : PDATA_W'(cur_thr);
        if (prdata !== want) begin
            $error("prdata: expected %0h, got %0h", want, prdata);
            fail_count++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Receiver: ready changes at the falling edge, with moods of its own and a long hold-off
    // on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(10, 80);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 3) != 0);
                default: i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (victims_due.size() == 0) begin
                $error("victim_way: expected nothing, got %0d", o_victim_way);
                fail_count++;
            end else begin
                way_due = victims_due.pop_front();
                if (o_victim_way !== way_due) begin
                    $error("victim_way: expected %0d, got %0d", way_due, o_victim_way);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_victim_basics();
        send_op(make_victim(11'd0, 16'hFFFF));
        send_op(make_victim(11'd0, 16'h0000));
        send_op(make_victim(11'd3, 16'h7FFF));
        send_op(make_victim(11'd3, 16'hFFFE));
        send_op(make_victim(11'd2047, 16'hFFFF));
    endtask

    task automatic test_hit_and_fill();
        send_op(make_access(11'd2047, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
        send_op(make_access(11'd2047, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
        send_op(make_access(11'd2047, 4'd15, 64'h0000_0000_0000_0001, 1'b0));
        send_op(make_victim(11'd2047, 16'hFFFF));
        send_op(make_access(11'd2047, 4'd0, 64'h0000_0000_0000_0040, 1'b1));
        send_op(make_access(11'd2047, 4'd1, 64'h0000_0000_0000_0080, 1'b0));
        send_op(make_victim(11'd2047, 16'hFFFF));
    endtask

    // A steady stride raises the set's score until misses insert at distant priority;
    // a negative delta and the unrepresentable delta then pull it back down.
    task automatic test_stride_detector();
        logic [ADDR_W-1:0] a;
        a = 64'h0000_0000_0000_1000;
        for (int k = 0; k < 5; k++) begin
            send_op(make_access(11'd9, 4'd2, a, 1'b1));
            a = a + 64'h40;
        end
        send_op(make_access(11'd9, 4'd4, a, 1'b0));
        send_op(make_access(11'd9, 4'd5, a - 64'h40, 1'b0));
        send_op(make_access(11'd9, 4'd6, a - 64'h40 + 64'h8000_0000, 1'b0));
        send_op(make_victim(11'd9, 16'hFFFF));
        send_op(make_victim(11'd9, 16'hFFFF));
    endtask

    task automatic test_random_traffic(input int count, input bit with_hold);
        int                burst_left;
        int                slot;
        int                pick;
        logic [SET_IDX_W-1:0] s;
        logic [MASK_W-1:0] m;
        logic [ADDR_W-1:0] a;
        burst_left = 0;
        for (int i = 0; i < count; i++) begin
            if (burst_left == 0) begin
                if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 8));
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            if (with_hold && i == count / 3) hold_request = 1'b1;
            slot = $urandom_range(0, POOL_SIZE - 1);
            s = ($urandom_range(0, 9) == 0) ? SET_IDX_W'($urandom_range(0, NUM_SETS - 1))
                                            : pool_set[slot];
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) m = 16'hFFFF;
                else if (pick < 85) m = ~(16'h1 << $urandom_range(0, NUM_WAYS - 1));
                else m = MASK_W'($urandom);
                send_op(make_victim(s, m));
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    a = {$urandom, $urandom};
                end else begin
                    if ($urandom_range(0, 15) == 0) begin
                        case ($urandom_range(0, 7))
                            0: pool_step[slot] = $urandom_range(70000, 200000);
                            1: pool_step[slot] = 0;
                            2: pool_step[slot] = int'(32'h8000_0000);
                            default: pool_step[slot] = $urandom_range(1, 400);
                        endcase
                        if ($urandom_range(0, 1) == 0) pool_step[slot] = -pool_step[slot];
                    end
                    pool_addr[slot] = pool_addr[slot] + longint'(pool_step[slot]);
                    a = pool_addr[slot];
                    s = pool_set[slot];
                end
                send_op(make_access(s, WAY_IDX_W'($urandom_range(0, NUM_WAYS - 1)), a,
                                    ($urandom_range(0, 99) < 55)));
            end
        end
    endtask

    initial begin
        for (int s = 0; s < NUM_SETS; s++) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                rrpv_tab[s][w] = RRPV_MAX;
                reuse_tab[s][w] = REUSE_INIT;
            end
            hist_addr[s] = '0;
            hist_delta[s] = '0;
            stream_lvl[s] = '0;
        end
        cur_limit = LIMIT_RESET;
        cur_thr = THR_RESET;
        for (int p = 0; p < POOL_SIZE; p++) begin
            pool_set[p] = SET_IDX_W'($urandom_range(0, NUM_SETS - 1));
            pool_addr[p] = {$urandom, $urandom};
            pool_step[p] = $urandom_range(1, 300);
        end
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_victim_basics();
        test_hit_and_fill();
        test_stride_detector();
        test_random_traffic(200, 1'b0);

        settle();
        write_reg(REG_STRIDE_LIMIT, 32'h0000_FFFF);
        write_reg(REG_STREAM_THR, 32'd0);
        test_random_traffic(200, 1'b1);

        settle();
        write_reg(REG_STRIDE_LIMIT, 32'd1);
        write_reg(REG_STREAM_THR, 32'd3);
        test_random_traffic(200, 1'b0);

        settle();
        write_reg(REG_STRIDE_LIMIT, 32'd0);
        write_reg(REG_STREAM_THR, 32'd1);
        test_random_traffic(150, 1'b0);

        settle();
        write_reg(REG_STRIDE_LIMIT, {16'hBEEF, 16'($urandom_range(64, 4096))});
        write_reg(REG_STREAM_THR, {$urandom} | 32'hFFFF_FFFC ^ 32'hFFFF_FFFC);
        test_random_traffic(280, 1'b0);

        idle_input(1);
        while (victims_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("stream_aware_rrip_replacement_core verification clean");
        end else begin
            $display("stream_aware_rrip_replacement_core verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/sarrip_pkg.sv
hdl/sarrip_row_update.sv
hdl/stream_aware_rrip_replacement_core.sv
verif/tb_stream_aware_rrip_replacement_core.sv
